>>> hw/rtl/peb_pkg.sv
package peb_pkg;

    typedef struct packed {
        logic start;
        logic is_div;
    } peb_req_t;

    localparam logic [1:0]  CFG_NORMAL_X = 2'd0;
    localparam logic [1:0]  CFG_NORMAL_Y = 2'd1;
    localparam logic [1:0]  CFG_NORMAL_Z = 2'd2;

    localparam logic [31:0] AXIS_ONE  = 32'h4000_0000;
    localparam logic [31:0] REF_LIMIT = 32'd966367641;

endpackage

>>> hw/rtl/plane_extent_bounds_core.sv
// The first point of a cloud builds the plane axes with the bit-serial square root, run once
// per vector, and the 64-step divider, run once per vector component.
// Every later finite point goes through the one shared 33x33 multiplier, a skipped point
// bypasses it; a waiting result holds the last point in the finish step.
// Throughput: one point in flight at a time; a result waits in the output register.
// Reset: bounds clear to empty, axes marked stale, normal returns to (0, 0, 1.0).
module plane_extent_bounds_core #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,   // point_x, point_y, point_z
    input  logic          s_tuser,   // point_finite
    input  logic          s_tlast,   // last_point
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // min_u, max_u, min_v, max_v
    output logic [1:0]    m_tuser    // no_support, normal_valid
);
    import peb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_NEG, S_MAG, S_NORM, S_SQ, S_RSTART, S_ROOT, S_DSTART, S_DIV,
        S_RET, S_TSEL, S_CROSS, S_CHECK, S_PROJ, S_UPD, S_FIN
    } state_t;

    typedef enum logic [1:0] {T_N, T_U, T_V} target_t;

    state_t              state_reg;
    target_t             target_reg;
    logic [3:0]          cnt_reg;
    logic [1:0]          idx_reg;
    logic                pass_reg;

    logic signed [31:0]  nx_reg, ny_reg, nz_reg;
    logic signed [31:0]  pt_reg [3];
    logic                fin_reg, last_reg;

    logic signed [63:0]  vec_reg [3];
    logic [63:0]         mag_reg [3];
    logic                neg_reg [3];
    logic signed [31:0]  res_reg [3];
    logic signed [31:0]  un_reg [3];
    logic signed [31:0]  axu_reg [3];
    logic signed [31:0]  axv_reg [3];

    logic signed [63:0]  acc_reg, prod_reg;
    logic [31:0]         root_reg;
    logic signed [31:0]  low_u_reg, high_u_reg, low_v_reg, high_v_reg;
    logic                seen_reg, ready_reg;

    logic                m_tvalid_reg;
    logic [127:0]        out_data_reg;
    logic [1:0]          out_user_reg;

    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  prod_full;
    logic [1:0]          i1, i2, ci, ki;
    logic                axes_ok;
    logic                flip;
    logic signed [63:0]  sum_r, shq;
    logic signed [31:0]  proj;
    logic [31:0]         un0_mag, q_cl;
    logic [63:0]         div_num;
    peb_req_t            sd_req;
    logic                sd_done;
    logic [31:0]         sd_result;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    assign axes_ok = (axu_reg[0] != 0) || (axu_reg[1] != 0) || (axu_reg[2] != 0);
    assign flip = (nx_reg < 0) ||
                  ((nx_reg == 0) && ((ny_reg < 0) || ((ny_reg == 0) && (nz_reg < 0))));
    assign un0_mag = un_reg[0][31] ? 32'(-un_reg[0]) : un_reg[0];

    assign ci = cnt_reg[3:2];
    assign ki = cnt_reg[2:1];

    always_comb
    begin
        case (ci)
            2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
            2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
            default: begin i1 = 2'd0; i2 = 2'd1; end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_SQ:
            begin
                mul_a = {2'b00, mag_reg[ki][30:0]};
                mul_b = {2'b00, mag_reg[ki][30:0]};
            end
            S_CROSS:
            begin
                mul_a = cnt_reg[1] ? 33'(un_reg[i2]) : 33'(un_reg[i1]);
                mul_b = cnt_reg[1] ? 33'(axu_reg[i1]) : 33'(axu_reg[i2]);
            end
            S_PROJ:
            begin
                mul_a = 33'(pt_reg[ki]);
                mul_b = pass_reg ? 33'(axv_reg[ki]) : 33'(axu_reg[ki]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    assign sum_r = acc_reg + 64'sh2000_0000;
    assign shq   = sum_r >>> 30;
    assign proj  = (shq > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                   (shq < -64'sh8000_0000) ? 32'sh8000_0000 : shq[31:0];

    assign div_num = {3'b000, mag_reg[idx_reg][30:0], 30'b0} + {33'b0, root_reg[31:1]};
    assign q_cl    = (sd_result > AXIS_ONE) ? AXIS_ONE : sd_result;

    assign sd_req.start  = (state_reg == S_RSTART) || (state_reg == S_DSTART);
    assign sd_req.is_div = (state_reg == S_DSTART);

    peb_sqdiv u_sqdiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (sd_req),
        .operand ((state_reg == S_DSTART) ? div_num : acc_reg),
        .divisor (root_reg),
        .done    (sd_done),
        .result  (sd_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            target_reg   <= T_N;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            pass_reg     <= 1'b0;
            nx_reg       <= '0;
            ny_reg       <= '0;
            nz_reg       <= 32'sd1 <<< COORD_FRAC_BITS;
            low_u_reg    <= 32'sh7FFF_FFFF;
            high_u_reg   <= 32'sh8000_0000;
            low_v_reg    <= 32'sh7FFF_FFFF;
            high_v_reg   <= 32'sh8000_0000;
            seen_reg     <= 1'b0;
            ready_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            acc_reg      <= '0;
            prod_reg     <= '0;
            root_reg     <= '0;
            fin_reg      <= 1'b0;
            last_reg     <= 1'b0;
            out_data_reg <= '0;
            out_user_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                pt_reg[i]  <= '0;
                vec_reg[i] <= '0;
                mag_reg[i] <= '0;
                neg_reg[i] <= 1'b0;
                res_reg[i] <= '0;
                un_reg[i]  <= '0;
                axu_reg[i] <= '0;
                axv_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_NORMAL_X: nx_reg <= cfg_data;
                    CFG_NORMAL_Y: ny_reg <= cfg_data;
                    CFG_NORMAL_Z: nz_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready && !((state_reg == S_FIN) && last_reg))
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        pt_reg[0] <= s_tdata[31:0];
                        pt_reg[1] <= s_tdata[63:32];
                        pt_reg[2] <= s_tdata[95:64];
                        fin_reg   <= s_tuser;
                        last_reg  <= s_tlast;
                        state_reg <= ready_reg ? S_CHECK : S_NEG;
                    end
                end
                S_NEG:
                begin
                    vec_reg[0] <= flip ? -64'(nx_reg) : 64'(nx_reg);
                    vec_reg[1] <= flip ? -64'(ny_reg) : 64'(ny_reg);
                    vec_reg[2] <= flip ? -64'(nz_reg) : 64'(nz_reg);
                    target_reg <= T_N;
                    state_reg  <= S_MAG;
                end
                S_MAG:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= vec_reg[i][63] ? 64'(-vec_reg[i]) : vec_reg[i];
                        neg_reg[i] <= vec_reg[i][63];
                    end
                    state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    if ((mag_reg[0] | mag_reg[1] | mag_reg[2]) == 64'd0)
                    begin
                        for (int i = 0; i < 3; i++)
                            res_reg[i] <= '0;
                        state_reg <= S_RET;
                    end
                    else if ((mag_reg[0][63:31] | mag_reg[1][63:31] | mag_reg[2][63:31]) != '0)
                    begin
                        for (int i = 0; i < 3; i++)
                            mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else if (!(mag_reg[0][30] | mag_reg[1][30] | mag_reg[2][30]))
                    begin
                        for (int i = 0; i < 3; i++)
                            mag_reg[i] <= mag_reg[i] << 1;
                    end
                    else
                    begin
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (!cnt_reg[0])
                        prod_reg <= prod_full[63:0];
                    else
                        acc_reg <= acc_reg + prod_reg;
                    if (cnt_reg == 4'd5)
                        state_reg <= S_RSTART;
                end
                S_RSTART:
                    state_reg <= S_ROOT;
                S_ROOT:
                begin
                    if (sd_done)
                    begin
                        root_reg  <= sd_result;
                        idx_reg   <= '0;
                        state_reg <= S_DSTART;
                    end
                end
                S_DSTART:
                    state_reg <= S_DIV;
                S_DIV:
                begin
                    if (sd_done)
                    begin
                        res_reg[idx_reg] <= neg_reg[idx_reg] ? -q_cl : q_cl;
                        if (idx_reg == 2'd2)
                        begin
                            state_reg <= S_RET;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= S_DSTART;
                        end
                    end
                end
                S_RET:
                begin
                    case (target_reg)
                        T_N:
                        begin
                            for (int i = 0; i < 3; i++)
                                un_reg[i] <= res_reg[i];
                            state_reg <= S_TSEL;
                        end
                        T_U:
                        begin
                            for (int i = 0; i < 3; i++)
                                axu_reg[i] <= res_reg[i];
                            acc_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_CROSS;
                        end
                        default:
                        begin
                            for (int i = 0; i < 3; i++)
                                axv_reg[i] <= res_reg[i];
                            ready_reg <= 1'b1;
                            state_reg <= S_CHECK;
                        end
                    endcase
                end
                S_TSEL:
                begin
                    if (un0_mag <= REF_LIMIT)
                    begin
                        vec_reg[0] <= '0;
                        vec_reg[1] <= 64'(un_reg[2]);
                        vec_reg[2] <= -64'(un_reg[1]);
                    end
                    else
                    begin
                        vec_reg[0] <= -64'(un_reg[2]);
                        vec_reg[1] <= '0;
                        vec_reg[2] <= 64'(un_reg[0]);
                    end
                    target_reg <= T_U;
                    state_reg  <= S_MAG;
                end
                S_CROSS:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (!cnt_reg[0])
                    begin
                        prod_reg <= prod_full[63:0];
                    end
                    else if (!cnt_reg[1])
                    begin
                        acc_reg <= acc_reg + prod_reg;
                    end
                    else
                    begin
                        vec_reg[ci] <= acc_reg - prod_reg;
                        acc_reg     <= '0;
                    end
                    if (cnt_reg == 4'd11)
                    begin
                        target_reg <= T_V;
                        state_reg  <= S_MAG;
                    end
                end
                S_CHECK:
                begin
                    if (axes_ok && fin_reg)
                    begin
                        pass_reg  <= 1'b0;
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_PROJ;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_PROJ:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (!cnt_reg[0])
                        prod_reg <= prod_full[63:0];
                    else
                        acc_reg <= acc_reg + prod_reg;
                    if (cnt_reg == 4'd5)
                        state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (!pass_reg)
                    begin
                        if (proj < low_u_reg)
                            low_u_reg <= proj;
                        if (proj > high_u_reg)
                            high_u_reg <= proj;
                        pass_reg  <= 1'b1;
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_PROJ;
                    end
                    else
                    begin
                        if (proj < low_v_reg)
                            low_v_reg <= proj;
                        if (proj > high_v_reg)
                            high_v_reg <= proj;
                        seen_reg  <= 1'b1;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        out_data_reg <= {high_v_reg, low_v_reg, high_u_reg, low_u_reg};
                        out_user_reg <= {axes_ok, axes_ok && !seen_reg};
                        low_u_reg    <= 32'sh7FFF_FFFF;
                        high_u_reg   <= 32'sh8000_0000;
                        low_v_reg    <= 32'sh7FFF_FFFF;
                        high_v_reg   <= 32'sh8000_0000;
                        seen_reg     <= 1'b0;
                        ready_reg    <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_support_needs_normal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[1])
        else $error("no_support raised without a valid normal");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        sd_done |-> (state_reg == S_ROOT) || (state_reg == S_DIV))
        else $error("iterative unit finished outside a wait state");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == S_FIN)
        else $error("result raised outside the finish step");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROOT) || (state_reg == S_DIV) |-> !s_tready)
        else $error("input taken while the axes are being built");

endmodule

>>> hw/rtl/peb_sqdiv.sv
module peb_sqdiv (
    input  logic              clk,
    input  logic              rst_n,
    input  peb_pkg::peb_req_t req,
    input  logic [63:0]       operand,
    input  logic [31:0]       divisor,
    output logic              done,
    output logic [31:0]       result
);
    import peb_pkg::*;

    logic        busy_reg;
    logic        mode_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] x_reg;
    logic [63:0] r_reg;
    logic [63:0] b_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] den_reg;

    logic [63:0] trial;
    logic [32:0] shifted;
    logic        fits;
    logic        last_step;

    assign trial     = r_reg + b_reg;
    assign shifted   = {rem_reg, x_reg[63]};
    assign fits      = shifted >= {1'b0, den_reg};
    assign last_step = mode_reg ? (cnt_reg == 6'd63) : (cnt_reg == 6'd31);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                mode_reg <= req.is_div;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= operand;
            r_reg   <= '0;
            b_reg   <= 64'h4000_0000_0000_0000;
            rem_reg <= '0;
            quo_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (mode_reg)
            begin
                x_reg   <= {x_reg[62:0], 1'b0};
                rem_reg <= fits ? 32'(shifted - {1'b0, den_reg}) : shifted[31:0];
                quo_reg <= {quo_reg[30:0], fits};
            end
            else
            begin
                if (x_reg >= trial)
                begin
                    x_reg <= x_reg - trial;
                    r_reg <= (r_reg >> 1) + b_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                b_reg <= b_reg >> 2;
            end
        end
    end

    assign done   = done_reg;
    assign result = mode_reg ? quo_reg : r_reg[31:0];

endmodule
